// ===== sv/dad_pkg.sv =====
// Shared types, constants and calendar helpers for the date-plus-days block.
`default_nettype none
package dad_pkg;

   localparam int unsigned YearW  = 14;
   localparam int unsigned MonthW = 4;
   localparam int unsigned DayW   = 5;
   localparam int unsigned AheadW = 16;
   localparam int unsigned PosW   = 17;
   localparam int unsigned RemW   = 14;
   localparam int unsigned CycW   = 9;
   localparam int unsigned ShiftW = 3;

   localparam logic [PosW-1:0]   ModBase  = 17'd400;
   localparam logic [ShiftW-1:0] ModTop   = 3'd5;
   localparam logic [CycW-1:0]   CycLast  = 9'd399;
   localparam logic [CycW-1:0]   Cent1    = 9'd100;
   localparam logic [CycW-1:0]   Cent2    = 9'd200;
   localparam logic [CycW-1:0]   Cent3    = 9'd300;
   localparam logic [MonthW-1:0] MonJan   = 4'd1;
   localparam logic [MonthW-1:0] MonFeb   = 4'd2;
   localparam logic [MonthW-1:0] MonDec   = 4'd12;

   typedef struct packed {
      logic [YearW-1:0]  start_year;
      logic [MonthW-1:0] start_month;
      logic [DayW-1:0]   start_day;
      logic [AheadW-1:0] days_ahead;
   } req_type;

   typedef struct packed {
      logic [YearW-1:0]  end_year;
      logic [MonthW-1:0] end_month;
      logic [DayW-1:0]   end_day;
   } rsp_type;

   typedef struct packed {
      logic [PosW-1:0] diff;
      logic            ge;
      logic            gt;
   } alu_res_type;

   function automatic logic [DayW-1:0] base_len(input logic [MonthW-1:0] mon);
      logic [DayW-1:0] len;
      case (mon)
         4'd2:                   len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== sv/dad_alu.sv =====
// Shared subtract and compare unit: difference plus greater-or-equal and greater-than flags.
`default_nettype none
module dad_alu
   import dad_pkg::*;
(
   input  wire logic [PosW-1:0] op_a,
   input  wire logic [PosW-1:0] op_b,
   output alu_res_type          res
);

   logic [PosW:0] wide;

   assign wide     = {1'b0, op_a} - {1'b0, op_b};
   assign res.diff = wide[PosW-1:0];
   assign res.ge   = ~wide[PosW];
   assign res.gt   = ~wide[PosW] && (wide[PosW-1:0] != '0);

endmodule
`default_nettype wire

// ===== sv/dad_cal.sv =====
// Month length lookup with the leap-year rule taken from the year mod 400.
`default_nettype none
module dad_cal
   import dad_pkg::*;
(
   input  wire logic [MonthW-1:0] mon,
   input  wire logic [CycW-1:0]   cyc,
   output logic      [DayW-1:0]   len
);

   logic leap;

   assign leap = (cyc == '0) ||
                 ((cyc[1:0] == 2'b00) && (cyc != Cent1) && (cyc != Cent2) && (cyc != Cent3));

   always_comb begin
      if (mon == MonFeb && leap) begin
         len = 5'd29;
      end else begin
         len = base_len(mon);
      end
   end

endmodule
`default_nettype wire

// ===== sv/date_add_days_top.sv =====
// Top level: sequencer that adds a day count to a Gregorian date month by month.
//
// An item is taken when start is high and busy is low; busy then stays high until the
// result is shown. The block first reduces the start year mod 400 in six restoring
// subtract steps, then crosses the month boundaries one at a time, both on the one
// shared subtractor. The result stands on rsp_item from the single cycle that
// rsp_strobe is high until the next result; it cannot be held off, so the receiver
// must take it then. busy falls in that same cycle.
`default_nettype none
module date_add_days_top
   import dad_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MOD  = 3'b010,
      ST_STEP = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [YearW:0]    yr_ff, yr_in;
   logic [RemW-1:0]   rem_ff, rem_in;
   logic [MonthW-1:0] mon_ff, mon_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [ShiftW-1:0] sh_ff, sh_in;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic [PosW-1:0]   op_a, op_b;
   alu_res_type       alu_res;
   logic [DayW-1:0]   mlen;
   logic [MonthW-1:0] mon_start;
   logic [CycW-1:0]   cyc;

   assign cyc = rem_ff[CycW-1:0];

   dad_alu u_alu (
      .op_a (op_a),
      .op_b (op_b),
      .res  (alu_res)
   );

   dad_cal u_cal (
      .mon (mon_ff),
      .cyc (cyc),
      .len (mlen)
   );

   always_comb begin
      if (state_ff == ST_MOD) begin
         op_a = PosW'(rem_ff);
         op_b = ModBase << sh_ff;
      end else begin
         op_a = pos_ff;
         op_b = PosW'(mlen);
      end
   end

   always_comb begin
      if (req_item.start_month == '0) begin
         mon_start = MonJan;
      end else if (req_item.start_month > MonDec) begin
         mon_start = MonDec;
      end else begin
         mon_start = req_item.start_month;
      end
   end

   always_comb begin
      state_in  = state_ff;
      yr_in     = yr_ff;
      rem_in    = rem_ff;
      mon_in    = mon_ff;
      pos_in    = pos_ff;
      sh_in     = sh_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               yr_in    = {1'b0, req_item.start_year};
               rem_in   = req_item.start_year;
               mon_in   = mon_start;
               pos_in   = PosW'(req_item.start_day) + PosW'(req_item.days_ahead);
               sh_in    = ModTop;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (alu_res.ge) begin
               rem_in = alu_res.diff[RemW-1:0];
            end
            sh_in = sh_ff - 3'd1;
            if (sh_ff == '0) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (alu_res.gt) begin
               pos_in = alu_res.diff;
               if (mon_ff == MonDec) begin
                  mon_in = MonJan;
                  yr_in  = yr_ff + 1'b1;
                  rem_in = (cyc == CycLast) ? '0 : rem_ff + 1'b1;
               end else begin
                  mon_in = mon_ff + 1'b1;
               end
            end else begin
               rsp_in.end_year  = yr_ff[YearW-1:0];
               rsp_in.end_month = mon_ff;
               rsp_in.end_day   = pos_ff[DayW-1:0];
               strobe_in        = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      yr_ff  <= yr_in;
      rem_ff <= rem_in;
      mon_ff <= mon_in;
      pos_ff <= pos_in;
      sh_ff  <= sh_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result shown while still busy");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (mon_ff >= MonJan && mon_ff <= MonDec))
      else $error("month left 1..12 while stepping");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (rem_ff <= RemW'(CycLast)))
      else $error("year cycle position out of range");

endmodule
`default_nettype wire
